// ----- rtl/core/nsc_pkg.sv -----
package nsc_pkg;

	localparam int MAX_SEEDS  = 256;
	localparam int COORD_BITS = 16;
	localparam int IDX_W      = $clog2(MAX_SEEDS);
	localparam int CNT_W      = $clog2(MAX_SEEDS + 1);
	localparam int SQ_W       = 2 * COORD_BITS;
	localparam int SUM_W      = SQ_W + 2;
	localparam int DIST_W     = 34;

	localparam logic [CNT_W-1:0] SEED_FULL = CNT_W'(MAX_SEEDS);
	localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(MAX_SEEDS - 1);
	localparam logic [1:0]       DIMS_RESET = 2'd3;
	localparam logic [1:0]       DIMS_MIN   = 2'd1;

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_LOAD  = 2'd1,
		KIND_QUERY = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [15:0] coord_x;
		logic signed [15:0] coord_y;
		logic signed [15:0] coord_z;
	} item_t;

	typedef struct packed {
		logic        found;
		logic [7:0]  seed_index;
		logic [33:0] min_dist_sq;
		logic        table_overflow;
	} result_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] z;
	} seed_t;

	typedef struct packed {
		logic load;
		logic rotate;
	} cell_ctl_t;

	typedef struct packed {
		logic             start;
		logic             valid;
		logic [IDX_W-1:0] idx;
	} scan_ctl_t;

	function automatic logic [COORD_BITS-1:0] abs_diff(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b
	);
		logic signed [COORD_BITS:0] d;
		d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
		if (d[COORD_BITS]) begin
			return COORD_BITS'(-d);
		end
		return COORD_BITS'(d);
	endfunction

	function automatic logic [DIST_W-1:0] sat_dist(input logic [SUM_W-1:0] s);
		if (SUM_W > DIST_W) begin
			if ((s >> DIST_W) != '0) begin
				return '1;
			end
		end
		return DIST_W'(s);
	endfunction

endpackage

// ----- rtl/core/nearest_seed_classifier.sv -----
// query: accepted, then scanned at one seed cell per cycle over all MAX_SEEDS cells
// (256), then the drain state; the done state loads the result when the output is free
// clear and load beats do not stall the input; one item in flight at a time
// the scan length is set by the rotating seed chain feeding one distance unit
// reset clears count, overflow flag, dimensions (to 3) and control; seed cells
// hold no reset value
module nearest_seed_classifier (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  nsc_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output nsc_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_data
);

	nsc_pkg::state_t                  state_q, state_d;
	logic [nsc_pkg::IDX_W-1:0]        scan_q;
	logic                             drain_q;
	logic [nsc_pkg::CNT_W-1:0]        count_q;
	logic                             ovf_q;
	logic [1:0]                       dims_q;
	logic [1:0]                       dims_eff;
	nsc_pkg::seed_t                   query_q;
	nsc_pkg::seed_t                   new_seed;
	nsc_pkg::seed_t                   cells [nsc_pkg::MAX_SEEDS];
	nsc_pkg::result_t                 result_q;
	logic                             result_valid_q;
	logic                             accept;
	logic                             result_load;
	nsc_pkg::cell_ctl_t               cell_ctl;
	nsc_pkg::scan_ctl_t               scan_ctl;
	logic [nsc_pkg::IDX_W-1:0]        best_idx;
	logic [nsc_pkg::DIST_W-1:0]       best_dist;

	assign cfg_ready = 1'b1;
	assign dims_eff  = (dims_q == 2'd0) ? nsc_pkg::DIMS_MIN : dims_q;

	assign new_seed.x = nsc_pkg::COORD_BITS'(item.coord_x);
	assign new_seed.y = nsc_pkg::COORD_BITS'(item.coord_y);
	assign new_seed.z = nsc_pkg::COORD_BITS'(item.coord_z);

	assign item_stall = (state_q != nsc_pkg::ST_IDLE);
	assign accept     = item_valid && !item_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			nsc_pkg::ST_IDLE: begin
				if (accept && item.kind == nsc_pkg::KIND_QUERY) begin
					state_d = nsc_pkg::ST_SCAN;
				end
			end
			nsc_pkg::ST_SCAN: begin
				if (scan_q == nsc_pkg::SCAN_LAST) begin
					state_d = nsc_pkg::ST_DRAIN;
				end
			end
			nsc_pkg::ST_DRAIN: begin
				if (drain_q) begin
					state_d = nsc_pkg::ST_DONE;
				end
			end
			nsc_pkg::ST_DONE: begin
				if (!result_valid_q || !result_stall) begin
					state_d = nsc_pkg::ST_IDLE;
				end
			end
			default: state_d = nsc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cell_ctl.load   = accept && item.kind == nsc_pkg::KIND_LOAD
		               && count_q < nsc_pkg::SEED_FULL;
		cell_ctl.rotate = (state_q == nsc_pkg::ST_SCAN);
		scan_ctl.start  = accept && item.kind == nsc_pkg::KIND_QUERY;
		scan_ctl.valid  = (state_q == nsc_pkg::ST_SCAN)
		               && (nsc_pkg::CNT_W'(scan_q) < count_q);
		scan_ctl.idx    = nsc_pkg::IDX_W'(count_q - nsc_pkg::CNT_W'(scan_q)
		               - nsc_pkg::CNT_W'(1));
		result_load     = (state_q == nsc_pkg::ST_DONE)
		               && (!result_valid_q || !result_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nsc_pkg::ST_IDLE;
			scan_q  <= '0;
			drain_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == nsc_pkg::ST_SCAN) begin
				scan_q <= scan_q + nsc_pkg::IDX_W'(1);
			end
			if (state_q == nsc_pkg::ST_DRAIN) begin
				drain_q <= !drain_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= nsc_pkg::DIMS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			dims_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			unique case (item.kind)
				nsc_pkg::KIND_CLEAR: begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end
				nsc_pkg::KIND_LOAD: begin
					if (count_q < nsc_pkg::SEED_FULL) begin
						count_q <= count_q + nsc_pkg::CNT_W'(1);
					end else begin
						ovf_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (scan_ctl.start) begin
			query_q <= new_seed;
		end
	end

	// seed chain: loads shift toward the tail, queries rotate toward the head
	for (genvar i = 0; i < nsc_pkg::MAX_SEEDS; i++) begin : g_cell
		nsc_pkg::seed_t left_in;
		if (i == 0) begin : g_head
			assign left_in = new_seed;
		end else begin : g_body
			assign left_in = cells[i - 1];
		end
		nsc_seed_cell u_cell (
			.clk       (clk),
			.ctl       (cell_ctl),
			.from_left (left_in),
			.from_right(cells[(i == nsc_pkg::MAX_SEEDS - 1) ? 0 : i + 1]),
			.seed      (cells[i])
		);
	end

	nsc_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.seed     (cells[0]),
		.query    (query_q),
		.dims     (dims_eff),
		.best_idx (best_idx),
		.best_dist(best_dist)
	);

	always_ff @(posedge clk) begin
		if (result_load) begin
			result_q.found          <= (count_q != '0);
			result_q.seed_index     <= 8'(best_idx);
			result_q.min_dist_sq    <= best_dist;
			result_q.table_overflow <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (result_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == nsc_pkg::ST_DONE))
		else $error("result beat raised outside done state");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= nsc_pkg::SEED_FULL)
		else $error("seed count beyond table depth");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> count_q == nsc_pkg::SEED_FULL)
		else $error("overflow flag set with room in table");

	a_scan_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nsc_pkg::ST_SCAN && scan_q != nsc_pkg::SCAN_LAST)
		|=> (state_q == nsc_pkg::ST_SCAN
		&& scan_q == $past(scan_q) + nsc_pkg::IDX_W'(1)))
		else $error("scan did not advance one cell");

endmodule

// ----- rtl/core/nsc_seed_cell.sv -----
module nsc_seed_cell (
	input  logic               clk,
	input  nsc_pkg::cell_ctl_t ctl,
	input  nsc_pkg::seed_t     from_left,
	input  nsc_pkg::seed_t     from_right,
	output nsc_pkg::seed_t     seed
);

	nsc_pkg::seed_t seed_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			seed_q <= from_left;
		end else if (ctl.rotate) begin
			seed_q <= from_right;
		end
	end

	assign seed = seed_q;

endmodule

// ----- rtl/core/nsc_dist.sv -----
module nsc_dist (
	input  logic                       clk,
	input  logic                       arst_n,
	input  nsc_pkg::scan_ctl_t         ctl,
	input  nsc_pkg::seed_t             seed,
	input  nsc_pkg::seed_t             query,
	input  logic [1:0]                 dims,
	output logic [nsc_pkg::IDX_W-1:0]  best_idx,
	output logic [nsc_pkg::DIST_W-1:0] best_dist
);

	logic                                valid_s1;
	logic [nsc_pkg::IDX_W-1:0]           idx_s1;
	logic [nsc_pkg::COORD_BITS-1:0]      mag_x_s1, mag_y_s1, mag_z_s1;
	logic                                valid_s2;
	logic [nsc_pkg::IDX_W-1:0]           idx_s2;
	logic [nsc_pkg::SQ_W-1:0]            sq_x_s2, sq_y_s2, sq_z_s2;
	logic [nsc_pkg::SUM_W-1:0]           sum;
	logic                                have_q;
	logic [nsc_pkg::SUM_W-1:0]           best_q;
	logic [nsc_pkg::IDX_W-1:0]           best_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= ctl.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= ctl.idx;
		mag_x_s1 <= nsc_pkg::abs_diff(query.x, seed.x);
		mag_y_s1 <= nsc_pkg::abs_diff(query.y, seed.y);
		mag_z_s1 <= nsc_pkg::abs_diff(query.z, seed.z);
		idx_s2   <= idx_s1;
		sq_x_s2  <= nsc_pkg::SQ_W'(mag_x_s1) * nsc_pkg::SQ_W'(mag_x_s1);
		sq_y_s2  <= (dims >= 2'd2)
		          ? nsc_pkg::SQ_W'(mag_y_s1) * nsc_pkg::SQ_W'(mag_y_s1) : '0;
		sq_z_s2  <= (dims >= 2'd3)
		          ? nsc_pkg::SQ_W'(mag_z_s1) * nsc_pkg::SQ_W'(mag_z_s1) : '0;
	end

	assign sum = nsc_pkg::SUM_W'(sq_x_s2) + nsc_pkg::SUM_W'(sq_y_s2)
	           + nsc_pkg::SUM_W'(sq_z_s2);

	// scan runs newest to oldest, so ties go to the seed scanned last (lower index)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q     <= 1'b0;
			best_q     <= '0;
			best_idx_q <= '0;
		end else if (ctl.start) begin
			have_q     <= 1'b0;
			best_q     <= '0;
			best_idx_q <= '0;
		end else if (valid_s2 && (!have_q || sum <= best_q)) begin
			have_q     <= 1'b1;
			best_q     <= sum;
			best_idx_q <= idx_s2;
		end
	end

	assign best_idx  = best_idx_q;
	assign best_dist = nsc_pkg::sat_dist(best_q);

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int PHASE_ITEMS = 290;
	localparam int SETTLE_CYCLES = 300;
	localparam longint CYCLE_LIMIT = 8000000;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	nsc_pkg::item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	nsc_pkg::result_t result;
	logic    cfg_valid = 1'b0;
	logic    cfg_ready;
	logic [1:0] cfg_data = 2'd0;

	nearest_seed_classifier i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	// shadow of the seed table and the dimensions register
	logic signed [15:0] seed_px [nsc_pkg::MAX_SEEDS];
	logic signed [15:0] seed_py [nsc_pkg::MAX_SEEDS];
	logic signed [15:0] seed_pz [nsc_pkg::MAX_SEEDS];
	int         seeds_held = 0;
	logic       overflow_seen = 1'b0;
	logic [1:0] dims_cfg = nsc_pkg::DIMS_RESET;

	nsc_pkg::item_t   item_backlog [$];
	nsc_pkg::result_t pending_labels [$];
	nsc_pkg::result_t label_due;
	int      errors = 0;
	int      phase_count;
	int      gap_left = 0;
	int      burst_left = 0;
	int      stall_run = 0;
	longint  cycles = 0;

	function automatic nsc_pkg::result_t nearest_seed(nsc_pkg::item_t it);
		nsc_pkg::result_t r;
		longint best, d, dx, dy, dz;
		int best_idx, axes;
		axes = (dims_cfg == 2'd0) ? 1 : int'(dims_cfg);
		best = 0;
		best_idx = 0;
		for (int i = 0; i < seeds_held; i++) begin
			dx = longint'(it.coord_x) - longint'(seed_px[i]);
			dy = longint'(it.coord_y) - longint'(seed_py[i]);
			dz = longint'(it.coord_z) - longint'(seed_pz[i]);
			d = dx * dx;
			if (axes >= 2) d += dy * dy;
			if (axes >= 3) d += dz * dz;
			if (i == 0 || d < best) begin
				best = d;
				best_idx = i;
			end
		end
		r.found = (seeds_held > 0);
		r.seed_index = best_idx[7:0];
		r.min_dist_sq = best[33:0];
		r.table_overflow = overflow_seen;
		return r;
	endfunction

	task automatic absorb_item(nsc_pkg::item_t it);
		case (it.kind)
			nsc_pkg::KIND_CLEAR: begin
				seeds_held = 0;
				overflow_seen = 1'b0;
			end
			nsc_pkg::KIND_LOAD: begin
				if (seeds_held >= nsc_pkg::MAX_SEEDS) begin
					overflow_seen = 1'b1;
				end else begin
					seed_px[seeds_held] = it.coord_x;
					seed_py[seeds_held] = it.coord_y;
					seed_pz[seeds_held] = it.coord_z;
					seeds_held++;
				end
			end
			nsc_pkg::KIND_QUERY: begin
				pending_labels = {pending_labels, nearest_seed(it)};
			end
			default: begin
			end
		endcase
	endtask

	task automatic push_item(logic [1:0] k, logic [15:0] x, logic [15:0] y,
		logic [15:0] z);
		nsc_pkg::item_t it;
		it.kind = k;
		it.coord_x = x;
		it.coord_y = y;
		it.coord_z = z;
		item_backlog = {item_backlog, it};
		if (k != KIND_UNUSED) phase_count++;
	endtask

	function automatic logic [15:0] rand_coord(int mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 6) - 3);
			default: begin
				case ($urandom_range(0, 3))
					0: return 16'h8000;
					1: return 16'h7fff;
					2: return 16'h0000;
					default: return 16'hffff;
				endcase
			end
		endcase
	endfunction

	task automatic add_sequence();
		int mode, n_loads, n_queries;
		mode = $urandom_range(0, 2);
		if ($urandom_range(0, 9) < 7) begin
			push_item(nsc_pkg::KIND_CLEAR, rand_coord(0), rand_coord(0), rand_coord(0));
		end
		if ($urandom_range(0, 59) == 0) begin
			n_loads = nsc_pkg::MAX_SEEDS + $urandom_range(0, 3);
		end else begin
			n_loads = $urandom_range(0, 12);
		end
		repeat (n_loads) begin
			push_item(nsc_pkg::KIND_LOAD, rand_coord(mode), rand_coord(mode),
				rand_coord(mode));
		end
		n_queries = $urandom_range(1, 6);
		repeat (n_queries) begin
			push_item(nsc_pkg::KIND_QUERY, rand_coord(mode), rand_coord(mode),
				rand_coord(mode));
		end
		if ($urandom_range(0, 7) == 0) begin
			push_item(2'($urandom_range(0, 3)), rand_coord(0), rand_coord(0), rand_coord(0));
		end
	endtask

	task automatic drain();
		while (item_backlog.size() != 0 || item_valid || pending_labels.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_dims(logic [1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		dims_cfg = v;
		cfg_valid <= 1'b0;
	endtask

	// sender: bursts with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) absorb_item(item);
			if (!item_valid || !item_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					item_valid <= 1'b0;
				end else if (item_backlog.size() > 0) begin
					item <= item_backlog.pop_front();
					item_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 15);
						case ($urandom_range(0, 9))
							0, 1, 2, 3, 4, 5: gap_left = 0;
							6, 7: gap_left = $urandom_range(1, 3);
							8: gap_left = $urandom_range(4, 40);
							default: gap_left = $urandom_range(41, 400);
						endcase
					end
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall pattern
	always @(posedge clk) begin
		if (stall_run > 0) begin
			stall_run--;
		end else begin
			case ($urandom_range(0, 3))
				0: begin
					result_stall <= 1'b0;
					stall_run = $urandom_range(1, 2000);
				end
				1: begin
					result_stall <= 1'b1;
					stall_run = $urandom_range(1, 4);
				end
				2: begin
					result_stall <= 1'b1;
					stall_run = $urandom_range(20, 300);
				end
				default: begin
					result_stall <= 1'b0;
					stall_run = $urandom_range(1, 8);
				end
			endcase
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_labels.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("unexpected result beat: found=%0d idx=%0d dist=%0d ovf=%0d",
						result.found, result.seed_index, result.min_dist_sq,
						result.table_overflow);
				end
			end else begin
				label_due = pending_labels.pop_front();
				if (result.found !== label_due.found
					|| result.seed_index !== label_due.seed_index
					|| result.min_dist_sq !== label_due.min_dist_sq
					|| result.table_overflow !== label_due.table_overflow) begin
					errors++;
					if (errors <= 10) begin
						$display({"mismatch: expected found=%0d idx=%0d dist=%0d ovf=%0d,",
							" got found=%0d idx=%0d dist=%0d ovf=%0d"},
							label_due.found, label_due.seed_index, label_due.min_dist_sq,
							label_due.table_overflow, result.found, result.seed_index,
							result.min_dist_sq, result.table_overflow);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	initial begin
		logic [1:0] dims_plan [6];
		dims_plan[0] = 2'd1;
		dims_plan[1] = 2'd2;
		dims_plan[2] = 2'd0;
		dims_plan[3] = 2'd3;
		dims_plan[4] = 2'($urandom_range(0, 3));
		dims_plan[5] = 2'($urandom_range(0, 3));
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, extremes, ties, ignored kind, clear
		phase_count = 0;
		push_item(nsc_pkg::KIND_QUERY, 16'h0000, 16'h0000, 16'h0000);
		push_item(nsc_pkg::KIND_QUERY, 16'h8000, 16'h7fff, 16'hffff);
		push_item(KIND_UNUSED, 16'h1234, 16'h5678, 16'h9abc);
		push_item(nsc_pkg::KIND_LOAD, 16'h8000, 16'h8000, 16'h8000);
		push_item(nsc_pkg::KIND_QUERY, 16'h7fff, 16'h7fff, 16'h7fff);
		push_item(nsc_pkg::KIND_QUERY, 16'h8000, 16'h8000, 16'h8000);
		push_item(nsc_pkg::KIND_LOAD, 16'h7fff, 16'h7fff, 16'h7fff);
		push_item(nsc_pkg::KIND_QUERY, 16'h0000, 16'h0000, 16'h0000);
		push_item(nsc_pkg::KIND_LOAD, 16'd5, 16'd5, 16'd5);
		push_item(nsc_pkg::KIND_LOAD, 16'd5, 16'd5, 16'd5);
		push_item(nsc_pkg::KIND_QUERY, 16'd5, 16'd5, 16'd5);
		push_item(nsc_pkg::KIND_QUERY, 16'd6, 16'd4, 16'd5);
		push_item(nsc_pkg::KIND_LOAD, 16'hffff, 16'h0000, 16'h0001);
		push_item(nsc_pkg::KIND_QUERY, 16'hffff, 16'h0000, 16'h0001);
		push_item(KIND_UNUSED, 16'hffff, 16'hffff, 16'hffff);
		push_item(nsc_pkg::KIND_QUERY, 16'h7fff, 16'h8000, 16'h7fff);
		push_item(nsc_pkg::KIND_CLEAR, 16'h0000, 16'h0000, 16'h0000);
		push_item(nsc_pkg::KIND_QUERY, 16'd5, 16'd5, 16'd5);
		push_item(nsc_pkg::KIND_LOAD, 16'd100, 16'hff9c, 16'h0000);
		push_item(nsc_pkg::KIND_QUERY, 16'd100, 16'hff9c, 16'h0000);
		drain();

		foreach (dims_plan[p]) begin
			write_dims(dims_plan[p]);
			phase_count = 0;
			while (phase_count < PHASE_ITEMS) add_sequence();
			drain();
		end

		if (errors == 0 && pending_labels.size() == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/nsc_pkg.sv
rtl/core/nsc_seed_cell.sv
rtl/core/nsc_dist.sv
rtl/core/nearest_seed_classifier.sv
dv/tb_top.sv
